[rtl/fan_duty_curve_with_kickstart_top_macros.svh]
// assertion macros for the fan duty curve block
// used by fan_duty_curve_with_kickstart_top; no other dependencies
`ifndef FAN_DUTY_CURVE_WITH_KICKSTART_TOP_MACROS_SVH
`define FAN_DUTY_CURVE_WITH_KICKSTART_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdc assertion failed");
// next-cycle implication
`define FDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdc assertion failed");
`else
`define FDC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/fdc_pkg.sv]
// shared types and constants of the fan duty curve block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package fdc_pkg;

    localparam int TEMP_W   = 13;
    localparam int DUTY_W   = 8;
    localparam int KICK_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int SPAN_W   = 13;
    localparam int REM_W    = 23;
    localparam int DSH_W    = 21;
    localparam int STEP_W   = 3;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN_EXCL = -13'sd640;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX_EXCL = 13'sd2400;
    localparam logic [DUTY_W-1:0]        FULL_DUTY     = 8'd255;
    localparam logic [8:0]               DUTY_SCALE2   = 9'd510;

    localparam logic                     RST_FAN_ENABLE = 1'b0;
    localparam logic signed [TEMP_W-1:0] RST_LOW_THR    = 13'sd640;
    localparam logic signed [TEMP_W-1:0] RST_HIGH_THR   = 13'sd1120;
    localparam logic [DUTY_W-1:0]        RST_MIN_SPIN   = 8'd80;
    localparam logic [KICK_W-1:0]        RST_KICK_LEN   = 16'd300;

    typedef enum logic {
        CMD_TICK   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAN_ENABLE = 3'd0,
        CFG_LOW_THR    = 3'd1,
        CFG_HIGH_THR   = 3'd2,
        CFG_MIN_SPIN   = 3'd3,
        CFG_KICK_LEN   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

[rtl/fdc_if.sv]
// valid/ready channel interfaces for the fan duty curve block
// depends on fdc_pkg for field widths
`default_nettype none

interface fdc_in_if;
    import fdc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sample_valid;

    modport source (output valid, cmd, temperature, sample_valid, input ready);
    modport sink   (input valid, cmd, temperature, sample_valid, output ready);
endinterface

interface fdc_out_if;
    import fdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              kicking;
    logic              duty_changed;

    modport source (output valid, duty, kicking, duty_changed, input ready);
    modport sink   (input valid, duty, kicking, duty_changed, output ready);
endinterface

`default_nettype wire

[rtl/fan_duty_curve_with_kickstart_top.sv]
// a tick or a sample outside the linear band goes from accept through S_CALC to S_FIN,
// a sample on the linear part of the curve through S_CALC, S_MUL and the S_DIV steps to S_FIN
// the 8-step shared restoring divider runs only for a sample on the linear part of the curve
// the input is not ready while an item is in flight; a full output register stalls the finish
// synchronous active-low reset: config to its defaults, duty and kick timer to zero
// depends on fdc_pkg, fdc_if.sv and fan_duty_curve_with_kickstart_top_macros.svh
`default_nettype none
`include "fan_duty_curve_with_kickstart_top_macros.svh"

module fan_duty_curve_with_kickstart_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [fdc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [fdc_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    fdc_in_if.sink                      i_in,
    fdc_out_if.source                   o_out
);
    import fdc_pkg::*;

    // configuration
    logic                     r_fan_enable;
    logic signed [TEMP_W-1:0] r_low_thr;
    logic signed [TEMP_W-1:0] r_high_thr;
    logic [DUTY_W-1:0]        r_min_spin;
    logic [KICK_W-1:0]        r_kick_len;

    // control and state
    t_state                   r_state, n_state;
    logic [DUTY_W-1:0]        r_duty, n_duty;
    logic [KICK_W-1:0]        r_kick, n_kick;
    logic [STEP_W-1:0]        r_step, n_step;
    logic                     r_out_valid, n_out_valid;

    // datapath
    logic                     r_cmd, n_cmd;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic                     r_sv, n_sv;
    logic [DUTY_W-1:0]        r_tgt, n_tgt;
    logic [SPAN_W-1:0]        r_num, n_num;
    logic [SPAN_W-1:0]        r_span, n_span;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [DSH_W-1:0]         r_dsh, n_dsh;
    logic [DUTY_W-1:0]        r_out_duty, n_out_duty;
    logic                     r_out_kicking, n_out_kicking;
    logic                     r_out_changed, n_out_changed;

    logic                     in_fire;
    logic                     out_free;
    logic signed [TEMP_W:0]   diff_num;
    logic signed [TEMP_W:0]   diff_span;
    logic [REM_W:0]           trial;
    logic [DUTY_W-1:0]        q_next;

    assign i_in.ready         = (r_state == S_IDLE);
    assign in_fire            = i_in.valid && i_in.ready;
    assign out_free           = !r_out_valid || o_out.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.duty         = r_out_duty;
    assign o_out.kicking      = r_out_kicking;
    assign o_out.duty_changed = r_out_changed;

    assign diff_num  = {r_temp[TEMP_W-1], r_temp} - {r_low_thr[TEMP_W-1], r_low_thr};
    assign diff_span = {r_high_thr[TEMP_W-1], r_high_thr} - {r_low_thr[TEMP_W-1], r_low_thr};
    // one subtractor shared by all quotient steps
    assign trial     = {1'b0, r_rem} - {{(REM_W+1-DSH_W){1'b0}}, r_dsh};
    assign q_next    = {r_tgt[DUTY_W-2:0], !trial[REM_W]};

    always_comb begin
        n_state       = r_state;
        n_duty        = r_duty;
        n_kick        = r_kick;
        n_step        = r_step;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_cmd         = r_cmd;
        n_temp        = r_temp;
        n_sv          = r_sv;
        n_tgt         = r_tgt;
        n_num         = r_num;
        n_span        = r_span;
        n_rem         = r_rem;
        n_dsh         = r_dsh;
        n_out_duty    = r_out_duty;
        n_out_kicking = r_out_kicking;
        n_out_changed = r_out_changed;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_cmd   = i_in.cmd;
                    n_temp  = i_in.temperature;
                    n_sv    = i_in.sample_valid;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_num  = diff_num[SPAN_W-1:0];
                n_span = diff_span[SPAN_W-1:0];
                n_state = S_FIN;
                if (!r_sv || r_temp <= TEMP_MIN_EXCL || r_temp >= TEMP_MAX_EXCL
                        || r_temp <= r_low_thr) begin
                    n_tgt = '0;
                end else if (r_temp >= r_high_thr) begin
                    n_tgt = FULL_DUTY;
                end else if (r_cmd == CMD_SAMPLE) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // numerator 510*num + span, divisor 2*span aligned to the top quotient bit
                n_rem   = REM_W'({10'd0, r_num} * {14'd0, DUTY_SCALE2}) + REM_W'(r_span);
                n_dsh   = {r_span, 1'b0, 7'd0};
                n_tgt   = '0;
                n_step  = '1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!trial[REM_W]) begin
                    n_rem = trial[REM_W-1:0];
                end
                n_tgt  = q_next;
                n_dsh  = r_dsh >> 1;
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    if (q_next != '0 && q_next < r_min_spin) begin
                        n_tgt = r_min_spin;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_changed = 1'b0;
                    if (r_cmd == CMD_TICK) begin
                        if (r_kick != '0) begin
                            n_kick = r_kick - 1'b1;
                        end
                    end else if (r_fan_enable) begin
                        if (r_tgt != '0 && r_duty == '0) begin
                            n_kick        = r_kick_len;
                            n_duty        = FULL_DUTY;
                            n_out_changed = 1'b1;
                        end else if (r_kick == '0 && r_tgt != r_duty) begin
                            n_duty        = r_tgt;
                            n_out_changed = 1'b1;
                        end
                    end
                    n_out_duty    = n_duty;
                    n_out_kicking = (n_kick != '0);
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_duty      <= '0;
            r_kick      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_duty      <= n_duty;
            r_kick      <= n_kick;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_temp        <= n_temp;
        r_sv          <= n_sv;
        r_tgt         <= n_tgt;
        r_num         <= n_num;
        r_span        <= n_span;
        r_rem         <= n_rem;
        r_dsh         <= n_dsh;
        r_out_duty    <= n_out_duty;
        r_out_kicking <= n_out_kicking;
        r_out_changed <= n_out_changed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_enable <= RST_FAN_ENABLE;
            r_low_thr    <= RST_LOW_THR;
            r_high_thr   <= RST_HIGH_THR;
            r_min_spin   <= RST_MIN_SPIN;
            r_kick_len   <= RST_KICK_LEN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FAN_ENABLE: begin
                    r_fan_enable <= i_cfg_wdata[0];
                end
                CFG_LOW_THR: begin
                    r_low_thr <= i_cfg_wdata[TEMP_W-1:0];
                end
                CFG_HIGH_THR: begin
                    r_high_thr <= i_cfg_wdata[TEMP_W-1:0];
                end
                CFG_MIN_SPIN: begin
                    r_min_spin <= i_cfg_wdata[DUTY_W-1:0];
                end
                CFG_KICK_LEN: begin
                    r_kick_len <= i_cfg_wdata[KICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a running kick always holds full duty
    `FDC_ASSERT_NOW(a_kick_full_duty, i_clk, i_rst_n, r_kick != '0, r_duty == FULL_DUTY)
    // the last quotient step hands over to the finish
    `FDC_ASSERT_NEXT(a_div_done, i_clk, i_rst_n, r_state == S_DIV && r_step == '0, r_state == S_FIN)
    // an accepted word is always classified next
    `FDC_ASSERT_NEXT(a_accept_calc, i_clk, i_rst_n, in_fire, r_state == S_CALC)

endmodule

`default_nettype wire
